// ===== design/pbvsb_pkg.sv =====
// Package for the page bitmap vertical shift blitter.
// Holds register index codes, field widths and parameter defaults.
// No dependencies.
package pbvsb_pkg;

    localparam int DISPLAY_WIDTH_DEF     = 132;
    localparam int RAM_PAGES_DEF         = 8;
    localparam int MAX_IMAGE_COLUMNS_DEF = 256;

    localparam int STORE_DEPTH = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_COLUMN  = 3'd0,
        REG_START_ROW     = 3'd1,
        REG_IMAGE_PAGES   = 3'd2,
        REG_IMAGE_COLUMNS = 3'd3,
        REG_INVERT_MODE   = 3'd4
    } cfg_reg_t;

endpackage

// ===== design/pbvsb_if.sv =====
// Valid/ready channel interfaces for the page bitmap vertical shift blitter.
// Input word carries one image byte, output word one display byte with address.
// No dependencies.
interface pbvsb_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface pbvsb_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_page;
    logic [7:0] out_column;
    logic [7:0] out_data;
    logic       last_of_run;

    modport source (output valid, output out_page, output out_column, output out_data,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_page, input out_column, input out_data,
                    input last_of_run, output ready);
endinterface

// ===== design/page_bitmap_vertical_shift_blitter_core.sv =====
// Stages: accepted input word in the stage-1 register, result word in the output register.
// Throughput: one input word per cycle while results are taken; an input word that yields
// both the last image page byte and the spill page byte holds the input until both are loaded.
// Reset: clears counters, pipeline valids and configuration to reset values;
// the previous-page line store is not cleared and needs no clearing pass.
// Top level; depends on pbvsb_pkg and pbvsb_if.
module page_bitmap_vertical_shift_blitter_core #(
    parameter int DISPLAY_WIDTH     = pbvsb_pkg::DISPLAY_WIDTH_DEF,
    parameter int RAM_PAGES         = pbvsb_pkg::RAM_PAGES_DEF,
    parameter int MAX_IMAGE_COLUMNS = pbvsb_pkg::MAX_IMAGE_COLUMNS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pbvsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbvsb_pkg::CFG_DATA_W-1:0] cfg_data,
    pbvsb_pixel_if.sink                      pixels,
    pbvsb_result_if.source                   results
);

    logic [7:0] start_column_reg;
    logic [6:0] start_row_reg;
    logic [4:0] image_pages_reg;
    logic [8:0] image_columns_reg;
    logic       invert_mode_reg;
    logic       cfg_hit;

    logic [3:0] page_cnt_reg;
    logic [7:0] col_cnt_reg;
    logic [4:0] pages_eff;
    logic [8:0] cols_eff;
    logic       col_wrap;
    logic       page_wrap;
    logic       in_fire;

    logic [7:0] prev_page_store [pbvsb_pkg::STORE_DEPTH];
    logic [7:0] prev_rd_reg;

    logic       s1_valid_reg;
    logic       s1_phase_reg;
    logic [7:0] s1_byte_reg;
    logic [7:0] s1_col_reg;
    logic [3:0] s1_page_reg;
    logic       s1_last_page_reg;

    logic [2:0]  offset;
    logic [15:0] cur_shifted;
    logic [15:0] prev_shifted;
    logic [7:0]  main_data;
    logic [7:0]  extra_data;
    logic [8:0]  disp_col;
    logic [4:0]  main_page;
    logic [4:0]  extra_page;
    logic        col_ok;
    logic        need_main;
    logic        need_extra;
    logic        out_free;
    logic        load_main;
    logic        load_extra;
    logic        s1_release;

    logic       out_valid_reg;
    logic [3:0] out_page_reg;
    logic [7:0] out_column_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pbvsb_pkg::REG_START_COLUMN,
                pbvsb_pkg::REG_START_ROW,
                pbvsb_pkg::REG_IMAGE_PAGES,
                pbvsb_pkg::REG_IMAGE_COLUMNS,
                pbvsb_pkg::REG_INVERT_MODE: cfg_hit = 1'b1;
                default:                    cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_column_reg  <= 8'd0;
            start_row_reg     <= 7'd0;
            image_pages_reg   <= 5'd1;
            image_columns_reg <= 9'd1;
            invert_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbvsb_pkg::REG_START_COLUMN:  start_column_reg  <= cfg_data[7:0];
                pbvsb_pkg::REG_START_ROW:     start_row_reg     <= cfg_data[6:0];
                pbvsb_pkg::REG_IMAGE_PAGES:   image_pages_reg   <= cfg_data[4:0];
                pbvsb_pkg::REG_IMAGE_COLUMNS: image_columns_reg <= cfg_data[8:0];
                pbvsb_pkg::REG_INVERT_MODE:   invert_mode_reg   <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // Clamp geometry
    always_comb
    begin
        pages_eff = image_pages_reg;
        if (image_pages_reg == 5'd0)
            pages_eff = 5'd1;
        else if (image_pages_reg > 5'd16)
            pages_eff = 5'd16;

        cols_eff = image_columns_reg;
        if (image_columns_reg == 9'd0)
            cols_eff = 9'd1;
        else if (image_columns_reg > 9'(MAX_IMAGE_COLUMNS))
            cols_eff = 9'(MAX_IMAGE_COLUMNS);
    end

    assign in_fire   = pixels.valid && pixels.ready;
    assign col_wrap  = ({1'b0, col_cnt_reg} + 9'd1) >= cols_eff;
    assign page_wrap = ({1'b0, page_cnt_reg} + 5'd1) >= pages_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_cnt_reg <= 4'd0;
            col_cnt_reg  <= 8'd0;
        end
        else if (cfg_hit)
        begin
            page_cnt_reg <= 4'd0;
            col_cnt_reg  <= 8'd0;
        end
        else if (in_fire)
        begin
            if (col_wrap)
            begin
                col_cnt_reg  <= 8'd0;
                page_cnt_reg <= page_wrap ? 4'd0 : page_cnt_reg + 4'd1;
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + 8'd1;
            end
        end
    end

    // Read old byte and store new one at the same column
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_rd_reg                  <= prev_page_store[col_cnt_reg];
            prev_page_store[col_cnt_reg] <= pixels.pixel_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg      <= pixels.pixel_byte;
            s1_col_reg       <= col_cnt_reg;
            s1_page_reg      <= page_cnt_reg;
            s1_last_page_reg <= page_wrap;
        end
    end

    always_comb
    begin
        offset       = start_row_reg[2:0];
        cur_shifted  = {8'h00, s1_byte_reg} << offset;
        prev_shifted = {8'h00, prev_rd_reg} << offset;
        main_data    = cur_shifted[7:0] | ((s1_page_reg != 4'd0) ? prev_shifted[15:8] : 8'h00);
        extra_data   = cur_shifted[15:8];
        disp_col     = {1'b0, start_column_reg} + {1'b0, s1_col_reg};
        main_page    = {1'b0, start_row_reg[6:3]} + {1'b0, s1_page_reg};
        extra_page   = main_page + 5'd1;
        col_ok       = disp_col < 9'(DISPLAY_WIDTH);
        need_main    = s1_valid_reg && !s1_phase_reg && col_ok
                       && (main_page < 5'(RAM_PAGES));
        need_extra   = s1_valid_reg && col_ok && (offset != 3'd0) && s1_last_page_reg
                       && (extra_page < 5'(RAM_PAGES));
        out_free     = !out_valid_reg || results.ready;
        load_main    = need_main && out_free;
        load_extra   = !need_main && need_extra && out_free;
        s1_release   = s1_valid_reg
                       && ((!need_main && !need_extra) || (out_free && !(need_main && need_extra)));
    end

    assign pixels.ready = !s1_valid_reg || s1_release;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_phase_reg <= 1'b0;
        end
        else if (s1_release)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load_main)
        begin
            s1_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_main || load_extra)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
        begin
            out_page_reg   <= main_page[3:0];
            out_column_reg <= disp_col[7:0];
            out_data_reg   <= main_data ^ {8{invert_mode_reg}};
            out_last_reg   <= !need_extra;
        end
        else if (load_extra)
        begin
            out_page_reg   <= extra_page[3:0];
            out_column_reg <= disp_col[7:0];
            out_data_reg   <= extra_data ^ {8{invert_mode_reg}};
            out_last_reg   <= 1'b1;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_page    = out_page_reg;
    assign results.out_column  = out_column_reg;
    assign results.out_data    = out_data_reg;
    assign results.last_of_run = out_last_reg;

endmodule

// ===== design/pbvsb_checker.sv =====
// Port-level checker for the page bitmap vertical shift blitter, with its bind.
// Depends on pbvsb_pkg for parameter defaults.
module pbvsb_checker #(
    parameter int DISPLAY_WIDTH = pbvsb_pkg::DISPLAY_WIDTH_DEF,
    parameter int RAM_PAGES     = pbvsb_pkg::RAM_PAGES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_page,
    input logic [7:0] out_column,
    input logic [7:0] out_data,
    input logic       last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_page) && $stable(out_column)
            && $stable(out_data) && $stable(last_of_run))
        else $error("result word changed while stalled");

    a_spill_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run
            && out_column == $past(out_column) && out_page == $past(out_page) + 4'd1)
        else $error("spill byte did not follow its page byte");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("input stalled with no result pending");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_column} < 9'(DISPLAY_WIDTH))
            && ({1'b0, out_page} < 5'(RAM_PAGES)))
        else $error("result outside display area");

endmodule

bind page_bitmap_vertical_shift_blitter_core pbvsb_checker #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .RAM_PAGES     (RAM_PAGES)
) u_pbvsb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixels.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_page    (results.out_page),
    .out_column  (results.out_column),
    .out_data    (results.out_data),
    .last_of_run (results.last_of_run)
);

// ===== tb/tb_page_bitmap_vertical_shift_blitter_core.sv =====
// Testbench for page_bitmap_vertical_shift_blitter_core: streams image bytes, checks every
// placed display word against an in-bench blit predictor under many placements and sizes.
// Depends on pbvsb_pkg, pbvsb_if and the core itself.
module tb_page_bitmap_vertical_shift_blitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_WORDS  = 480;
    localparam int PHASE_CAP     = 90;
    localparam int IDX_W         = pbvsb_pkg::CFG_IDX_W;
    localparam int DATA_W        = pbvsb_pkg::CFG_DATA_W;

    typedef struct {
        logic [3:0] page;
        logic [7:0] column;
        logic [7:0] data;
        logic       last;
    } display_word_t;

    class blit_scoreboard;
        display_word_t expected[$];
        int            errors;
        logic [7:0]    line_store [pbvsb_pkg::STORE_DEPTH];
        int            page_count;
        int            column_count;
        logic [7:0]    start_column;
        logic [6:0]    start_row;
        logic [4:0]    image_pages;
        logic [8:0]    image_columns;
        logic          invert_mode;

        function new();
            errors        = 0;
            page_count    = 0;
            column_count  = 0;
            start_column  = '0;
            start_row     = '0;
            image_pages   = 5'd1;
            image_columns = 9'd1;
            invert_mode   = 1'b0;
        endfunction

        function void set_register(logic [IDX_W-1:0] index, logic [DATA_W-1:0] value);
            case (index)
                pbvsb_pkg::REG_START_COLUMN:  start_column  = value[7:0];
                pbvsb_pkg::REG_START_ROW:     start_row     = value[6:0];
                pbvsb_pkg::REG_IMAGE_PAGES:   image_pages   = value[4:0];
                pbvsb_pkg::REG_IMAGE_COLUMNS: image_columns = value[8:0];
                pbvsb_pkg::REG_INVERT_MODE:   invert_mode   = value[0];
                default:                      return;
            endcase
            page_count   = 0;
            column_count = 0;
        endfunction

        function int place(int page, int column, logic [7:0] data);
            display_word_t w;
            if (page >= pbvsb_pkg::RAM_PAGES_DEF || column >= pbvsb_pkg::DISPLAY_WIDTH_DEF)
                return 0;
            w.page   = 4'(page);
            w.column = 8'(column);
            w.data   = invert_mode ? ~data : data;
            w.last   = 1'b0;
            expected.push_back(w);
            return 1;
        endfunction

        function void note_input(logic [7:0] pixel);
            int         shift;
            int         base;
            int         pages;
            int         cols;
            int         column;
            int         placed;
            logic [7:0] merged;
            shift  = start_row[2:0];
            base   = start_row[6:3];
            pages  = (image_pages == 0) ? 1 : (image_pages > 16) ? 16 : image_pages;
            cols   = (image_columns == 0) ? 1 :
                     (image_columns > pbvsb_pkg::MAX_IMAGE_COLUMNS_DEF) ?
                     pbvsb_pkg::MAX_IMAGE_COLUMNS_DEF : image_columns;
            column = start_column + column_count;
            merged = pixel << shift;
            if (page_count > 0 && shift != 0)
                merged = merged | (line_store[column_count] >> (8 - shift));
            placed = place(base + page_count, column, merged);
            if (shift != 0 && page_count + 1 >= pages)
                placed += place(base + page_count + 1, column, pixel >> (8 - shift));
            if (placed > 0)
                expected[expected.size() - 1].last = 1'b1;
            line_store[column_count] = pixel;
            if (column_count + 1 >= cols)
            begin
                column_count = 0;
                page_count   = (page_count + 1 >= pages) ? 0 : page_count + 1;
            end
            else
            begin
                column_count++;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(display_word_t got);
            display_word_t want;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected word page %0d column %0d data %h last %b",
                                 got.page, got.column, got.data, got.last));
                return;
            end
            want = expected.pop_front();
            if (got.page !== want.page)
                report($sformatf("page %0d, want %0d", got.page, want.page));
            if (got.column !== want.column)
                report($sformatf("column %0d, want %0d", got.column, want.column));
            if (got.data !== want.data)
                report($sformatf("data %h, want %h (page %0d column %0d)",
                                 got.data, want.data, want.page, want.column));
            if (got.last !== want.last)
                report($sformatf("last_of_run %b, want %b (page %0d column %0d)",
                                 got.last, want.last, want.page, want.column));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    bit                tx_calm;
    bit                rx_calm;
    int                words_sent;
    int                cycles = 0;
    blit_scoreboard    sc = new();

    pbvsb_pixel_if  pix();
    pbvsb_result_if res();

    page_bitmap_vertical_shift_blitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .results   (res)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] index, int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= DATA_W'(value);
        @(posedge clk);
        sc.set_register(index, DATA_W'(value));
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        while (sc.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic setup_image(int col, int row, int pages, int cols, int invert);
        settle();
        write_reg(pbvsb_pkg::REG_START_COLUMN, col);
        write_reg(pbvsb_pkg::REG_START_ROW, row);
        write_reg(pbvsb_pkg::REG_IMAGE_PAGES, pages);
        write_reg(pbvsb_pkg::REG_IMAGE_COLUMNS, cols);
        write_reg(pbvsb_pkg::REG_INVERT_MODE, invert);
        cfg_we <= 1'b0;
    endtask

    // unlisted indexes must neither change a register nor restart the image
    task automatic touch_unused();
        settle();
        for (int k = pbvsb_pkg::REG_INVERT_MODE + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), $urandom_range(0, 511));
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic [7:0] value);
        int gap;
        gap = tx_calm ? 0 : draw_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_byte <= value;
        do @(posedge clk); while (pix.ready !== 1'b1);
        sc.note_input(value);
        words_sent++;
    endtask

    task automatic directed();
        send_word(8'h00);
        send_word(8'hFF);

        setup_image(128, 45, 2, 5, 1);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'h80);
        send_word(8'h01);
        send_word(8'h5A);
        send_word(8'hFF);
        touch_unused();
        send_word(8'h01);
        send_word(8'h80);
        send_word(8'h00);
        send_word(8'hC3);

        setup_image(255, 127, 0, 0, 0);
        send_word(8'hFF);
        send_word(8'h3C);

        setup_image(0, 7, 31, 511, 1);
        send_word(8'hFF);
        send_word(8'h81);
        send_word(8'h7E);

        setup_image(0, 49, 3, 2, 0);
        repeat (6) send_word(8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase();
        int col;
        int row;
        int pages;
        int cols;
        int span;
        int n;
        col   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 140) : $urandom_range(0, 255);
        row   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 127);
        pages = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 31);
        cols  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 10) : $urandom_range(0, 511);
        span  = ((pages == 0) ? 1 : (pages > 16) ? 16 : pages) *
                ((cols == 0) ? 1 : (cols > pbvsb_pkg::MAX_IMAGE_COLUMNS_DEF) ?
                 pbvsb_pkg::MAX_IMAGE_COLUMNS_DEF : cols);
        n     = span * $urandom_range(1, 3)
                + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        if (n > PHASE_CAP)
            n = PHASE_CAP - $urandom_range(0, 10);
        setup_image(col, row, pages, cols, $urandom_range(0, 1));
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
            touch_unused();
        end
        repeat (n) send_word(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : result_sink
        int            gap;
        display_word_t got;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_calm ? 0 : draw_gap();
            if (gap > 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (res.valid !== 1'b1);
            got.page   = res.out_page;
            got.column = res.out_column;
            got.data   = res.out_data;
            got.last   = res.last_of_run;
            sc.check_result(got);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        words_sent     = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        pix.valid      <= 1'b0;
        pix.pixel_byte <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        while (words_sent < TARGET_WORDS)
            random_phase();

        settle();
        if (sc.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
design/pbvsb_pkg.sv
design/pbvsb_if.sv
design/page_bitmap_vertical_shift_blitter_core.sv
design/pbvsb_checker.sv
tb/tb_page_bitmap_vertical_shift_blitter_core.sv
